// ===== design/apa_pkg.sv =====
`timescale 1ns / 1ps

package apa_pkg;

   // Number of zero bytes that open a frame.
   localparam int unsigned START_BYTES = 4;
   localparam int unsigned START_CNT_W = (START_BYTES > 1) ? $clog2(START_BYTES) : 1;

   // Fixed byte codes of the serial frame.
   localparam logic [7:0] START_CODE = 8'h00;
   localparam logic [7:0] HEAD_CODE  = 8'hFF;
   localparam logic [7:0] END_CODE   = 8'hFF;

   // Brightness limit and divide-by-100 reciprocal.
   // The value floor(x * 5243 / 2^19) equals floor(x / 100) for x up to 25500.
   localparam logic [6:0]  MAX_PERCENT = 7'd100;
   localparam int unsigned PROD_W      = 15;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int unsigned QUOT_W      = PROD_W + 13;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } pixel_type;

   typedef struct packed {
      logic [PROD_W-1:0] red;
      logic [PROD_W-1:0] green;
      logic [PROD_W-1:0] blue;
      logic              last;
   } product_type;

   typedef enum logic [2:0] {
      ST_START,
      ST_HEAD,
      ST_BLUE,
      ST_GREEN,
      ST_RED,
      ST_END
   } seq_state_type;

   // Scale a product c*p down by one hundred.
   function automatic logic [7:0] div100(input logic [PROD_W-1:0] x);
      logic [QUOT_W-1:0] wide;
      wide = QUOT_W'(x) * QUOT_W'(RECIP_100);
      return wide[RECIP_SHIFT +: 8];
   endfunction

endpackage

// ===== design/apa102_frame_builder_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                            Content
// req       in         req_tvalid/tready/tdata/tlast   pixel colours, last pixel flag
// rsp       out        rsp_tvalid/tready/tdata/tlast   frame byte, last byte of the pixel
// csr       in         csr_valid/ready/data            brightness percent
//
// Each pixel yields four bytes (header, blue, green, red) at one byte per cycle
// while rsp is not stalled, plus four start bytes when no frame is open and one
// end byte on the last pixel. The byte sequencer takes the next pixel as it emits
// the last byte of the one before. A req transaction reaches its first byte
// through the input, product, sequencer and output registers.
// Reset is synchronous; afterwards the brightness is 100 and no frame is open.
// A stall on rsp holds the output byte; pixels keep filling the pipeline meanwhile.

module apa102_frame_builder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic        req_tlast,   // last_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // brightness_percent [7:0]
);
   import apa_pkg::*;

   logic [7:0] brightness_ff, brightness_in;
   logic [6:0] percent;
   pixel_type  req_pixel;
   pixel_type  scaled_pixel;
   logic       scaled_valid, scaled_ready;

   // Brightness register; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      brightness_in = brightness_ff;
      if (csr_valid) begin
         brightness_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 8'd100;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   // Values above one hundred act as one hundred.
   assign percent = (brightness_ff > 8'(MAX_PERCENT)) ? MAX_PERCENT : brightness_ff[6:0];

   // Unpack the pixel.
   assign req_pixel.red   = req_tdata[7:0];
   assign req_pixel.green = req_tdata[15:8];
   assign req_pixel.blue  = req_tdata[23:16];
   assign req_pixel.last  = req_tlast;

   apa_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (req_pixel),
      .percent   (percent),
      .out_valid (scaled_valid),
      .out_ready (scaled_ready),
      .out_pixel (scaled_pixel)
   );

   apa_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scaled_valid),
      .in_ready  (scaled_ready),
      .in_pixel  (scaled_pixel),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== design/apa_scale.sv =====
`timescale 1ns / 1ps

module apa_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  apa_pkg::pixel_type  in_pixel,
   input  logic [6:0]          percent,
   output logic                out_valid,
   input  logic                out_ready,
   output apa_pkg::pixel_type  out_pixel
);
   import apa_pkg::*;

   logic        a_valid_ff, a_valid_in;
   pixel_type   a_pixel_ff, a_pixel_in;
   logic        b_valid_ff, b_valid_in;
   product_type b_prod_ff, b_prod_in;
   logic        a_ready, b_ready;

   // Each stage moves on when the one after it is empty or draining.
   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Input stage.
   always_comb begin
      a_valid_in = a_valid_ff;
      a_pixel_in = a_pixel_ff;
      if (a_ready) begin
         a_valid_in = in_valid;
         a_pixel_in = in_pixel;
      end
   end

   // Product stage: each colour times the saturated percentage.
   always_comb begin
      b_valid_in = b_valid_ff;
      b_prod_in  = b_prod_ff;
      if (b_ready) begin
         b_valid_in      = a_valid_ff;
         b_prod_in.red   = PROD_W'(a_pixel_ff.red) * PROD_W'(percent);
         b_prod_in.green = PROD_W'(a_pixel_ff.green) * PROD_W'(percent);
         b_prod_in.blue  = PROD_W'(a_pixel_ff.blue) * PROD_W'(percent);
         b_prod_in.last  = a_pixel_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pixel_ff <= a_pixel_in;
      b_prod_ff  <= b_prod_in;
   end

   // Divide by one hundred on the way into the sequencer register.
   assign out_valid       = b_valid_ff;
   assign out_pixel.red   = div100(b_prod_ff.red);
   assign out_pixel.green = div100(b_prod_ff.green);
   assign out_pixel.blue  = div100(b_prod_ff.blue);
   assign out_pixel.last  = b_prod_ff.last;

endmodule

// ===== design/apa_serializer.sv =====
`timescale 1ns / 1ps

module apa_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  apa_pkg::pixel_type in_pixel,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_last
);
   import apa_pkg::*;

   logic                   pix_valid_ff, pix_valid_in;
   pixel_type              pix_ff, pix_in;
   seq_state_type          state_ff, state_in;
   logic [START_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   frame_open_ff, frame_open_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic       emit, done, load;
   logic [7:0] cur_byte;
   logic       cur_final;

   // A byte is emitted when a pixel is held and the output register frees up.
   assign emit     = pix_valid_ff && (!rsp_valid_ff || out_ready);
   assign done     = emit && cur_final;
   assign in_ready = !pix_valid_ff || done;
   assign load     = in_valid && in_ready;

   // Frame state: opened by the header of a pixel, closed by the end byte.
   always_comb begin
      frame_open_in = frame_open_ff;
      if (emit && (state_ff == ST_HEAD)) begin
         frame_open_in = 1'b1;
      end else if (emit && (state_ff == ST_END)) begin
         frame_open_in = 1'b0;
      end
   end

   // Next state of the byte sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         state_in = frame_open_in ? ST_HEAD : ST_START;
         cnt_in   = '0;
      end else if (emit) begin
         unique case (state_ff)
            ST_START: begin
               if (cnt_ff == START_CNT_W'(START_BYTES - 1)) begin
                  state_in = ST_HEAD;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_HEAD:  state_in = ST_BLUE;
            ST_BLUE:  state_in = ST_GREEN;
            ST_GREEN: state_in = ST_RED;
            ST_RED:   state_in = pix_ff.last ? ST_END : ST_RED;
            ST_END:   state_in = ST_END;
            default:  state_in = ST_HEAD;
         endcase
      end
   end

   // Byte chosen in each state, and whether it closes the pixel's run.
   always_comb begin
      cur_byte  = START_CODE;
      cur_final = 1'b0;
      unique case (state_ff)
         ST_START: cur_byte = START_CODE;
         ST_HEAD:  cur_byte = HEAD_CODE;
         ST_BLUE:  cur_byte = pix_ff.blue;
         ST_GREEN: cur_byte = pix_ff.green;
         ST_RED: begin
            cur_byte  = pix_ff.red;
            cur_final = !pix_ff.last;
         end
         ST_END: begin
            cur_byte  = END_CODE;
            cur_final = 1'b1;
         end
         default: cur_byte = START_CODE;
      endcase
   end

   // Pixel holding register.
   always_comb begin
      pix_valid_in = pix_valid_ff;
      pix_in       = pix_ff;
      if (load) begin
         pix_valid_in = 1'b1;
         pix_in       = in_pixel;
      end else if (done) begin
         pix_valid_in = 1'b0;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = cur_final;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff  <= 1'b0;
         state_ff      <= ST_START;
         cnt_ff        <= '0;
         frame_open_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pix_valid_ff  <= pix_valid_in;
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         frame_open_ff <= frame_open_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_byte  = rsp_byte_ff;
   assign out_last  = rsp_last_ff;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Pixels go in on req and frame bytes come out on rsp. A software copy of the
// frame encoder tracks the open frame and the brightness, and turns every
// accepted pixel into the bytes it must produce. Those bytes wait in a queue
// and are checked in order against each rsp transaction.
module tb_top;
   import apa_pkg::*;

   localparam int RSP_LATENCY = 4;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [7:0] value;
      logic       run_end;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   // Encoder state as seen from outside.
   logic [7:0]     brightness = 8'd100;
   logic           frame_open = 1'b0;
   frame_byte_type pending_bytes[$];

   int          mismatch_count = 0;
   int          stall_cycles = 0;
   int          hold_left = 0;
   bit          idle_on = 1'b0;

   apa102_frame_builder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Colour scaled by the saturated brightness, rounded down.
   function automatic logic [7:0] scaled_colour(logic [7:0] colour, logic [7:0] pct);
      int unsigned product;
      product = colour * pct;
      return 8'(product / 100);
   endfunction

   // Append one expected byte at the tail of the queue.
   function automatic void push_byte(logic [7:0] value, logic run_end);
      frame_byte_type entry;
      entry.value = value;
      entry.run_end = run_end;
      pending_bytes = {pending_bytes, entry};
   endfunction

   // Queue the frame bytes that one accepted pixel must produce.
   function automatic void encode_pixel(logic [7:0] red, logic [7:0] green,
                                        logic [7:0] blue, logic last_flag);
      logic [7:0] pct;
      pct = (brightness > MAX_PERCENT) ? 8'(MAX_PERCENT) : brightness;
      if (!frame_open) begin
         for (int i = 0; i < START_BYTES; i++) begin
            push_byte(START_CODE, 1'b0);
         end
         frame_open = 1'b1;
      end
      push_byte(HEAD_CODE, 1'b0);
      push_byte(scaled_colour(blue, pct), 1'b0);
      push_byte(scaled_colour(green, pct), 1'b0);
      push_byte(scaled_colour(red, pct), !last_flag);
      if (last_flag) begin
         push_byte(END_CODE, 1'b1);
         frame_open = 1'b0;
      end
   endfunction

   // Offer one pixel, with random idle cycles ahead of it when enabled.
   task automatic send_pixel(logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue, logic last_flag);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 25) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid = 1'b1;
      req_tdata = {blue, green, red};
      req_tlast = last_flag;
      do @(posedge clock); while (!req_tready);
      encode_pixel(red, green, blue, last_flag);
      @(negedge clock);
   endtask

   task automatic send_random_pixel(logic last_flag);
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), last_flag);
   endtask

   // Stop offering pixels and wait for every queued byte to come out.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_bytes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // The brightness register is only written with the block idle.
   task automatic write_brightness(logic [7:0] value);
      wait_drained();
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      brightness = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Reset brightness of 100, single-pixel and two-pixel frames and extreme colour values.
   task automatic test_defaults_after_reset();
      idle_on = 1'b0;
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'hAA, 8'h55, 8'hFF, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h00, 1'b1);
      wait_drained();
   endtask

   // Zero, saturated and intermediate brightness values.
   task automatic test_brightness_extremes();
      idle_on = 1'b1;
      write_brightness(8'd0);
      send_pixel(8'hFF, 8'h80, 8'h01, 1'b1);
      write_brightness(8'd255);
      send_pixel(8'd200, 8'hFF, 8'd7, 1'b0);
      send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
      write_brightness(8'd50);
      send_pixel(8'hFF, 8'd101, 8'd99, 1'b0);
      send_pixel(8'd3, 8'd1, 8'd200, 1'b1);
      write_brightness(8'd1);
      send_pixel(8'hFF, 8'd99, 8'd100, 1'b1);
      write_brightness(8'd101);
      send_pixel(8'd250, 8'd251, 8'd252, 1'b1);
      write_brightness(8'd99);
      send_pixel(8'hFF, 8'hFE, 8'h7F, 1'b1);
      write_brightness(8'd100);
      wait_drained();
   endtask

   // The receiver holds off for a long time while pixels keep coming.
   task automatic test_output_backpressure();
      idle_on = 1'b0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      for (int i = 0; i < 20; i++) begin
         send_random_pixel(i % 7 == 6);
      end
      wait_drained();
   endtask

   // Random frames under random brightness settings, with some broken framing.
   task automatic test_random_frames();
      int frame_len;
      int sent;
      for (int phase = 0; phase < 8; phase++) begin
         idle_on = (phase != 3);
         case (phase % 4)
            0: write_brightness(8'($urandom_range(0, 100)));
            1: write_brightness(8'($urandom_range(101, 255)));
            default: write_brightness(8'($urandom));
         endcase
         sent = 0;
         while (sent < 12) begin
            frame_len = $urandom_range(1, 6);
            for (int i = 0; i < frame_len; i++) begin
               if ($urandom_range(0, 99) < 15) begin
                  send_random_pixel(1'($urandom));
               end else begin
                  send_random_pixel(i == frame_len - 1);
               end
               sent++;
            end
         end
      end
      wait_drained();
   endtask

   // Receiver: a long hold-off on request, otherwise random idle cycles.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (idle_on) begin
         rsp_tready <= ($urandom_range(0, 99) >= 25);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each output byte with the oldest queued byte.
   always @(posedge clock) begin : check_byte
      frame_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $error("out_byte: no byte expected, actual %02h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("out_byte: expected %02h, actual %02h", want.value, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.run_end) begin
               $error("last_of_run: expected %0b, actual %0b", want.run_end, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no transaction of any kind takes place.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults_after_reset();
      test_brightness_extremes();
      test_output_backpressure();
      test_random_frames();
      wait_drained();
      repeat (RSP_LATENCY * 4) @(posedge clock);
      if (mismatch_count == 0 && pending_bytes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
